[sv/cfr_pkg.sv]
// Shared constants, command/request types and codes for the clipped rectangle fill framebuffer.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 192;
	localparam int STORE_WORDS = (MAX_WIDTH * MAX_HEIGHT + 1) / 2;

	// Derived widths
	localparam int ADDR_W = $clog2(STORE_WORDS);
	localparam int CNT_W  = $clog2(STORE_WORDS + 1);
	localparam int PIX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int X_W    = $clog2(MAX_WIDTH + 1);
	localparam int Y_W    = $clog2(MAX_HEIGHT + 1);
	localparam int PROD_W = X_W + Y_W;

	// Field widths
	localparam int COORD_W   = 12;
	localparam int CLIP_W    = COORD_W + 1;
	localparam int COLOR_W   = 8;
	localparam int RADDR_W   = 15;
	localparam int WORD_W    = 16;
	localparam int CFG_WID_W = 9;
	localparam int CFG_HGT_W = 8;

	// Port widths
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_HEIGHT = 1'b1;

	localparam logic signed [CLIP_W-1:0] CLIP_NEG_ONE = -13'sd1;

	typedef enum logic [1:0] {
		OP_FILL_RECT   = 2'd0,
		OP_FILL_SCREEN = 2'd1,
		OP_READ_WORD   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_SCAN,
		ST_FILL,
		ST_RDWAIT,
		ST_DONE
	} scan_state_t;

	// One accepted command
	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  rect_top;
		logic signed [COORD_W-1:0]  rect_bottom;
		logic signed [COORD_W-1:0]  rect_left;
		logic signed [COORD_W-1:0]  rect_right;
		logic [COLOR_W-1:0]         pixel_color;
		logic [RADDR_W-1:0]         read_address;
	} cmd_t;

	// Sequencer to store: one memory operation per cycle
	typedef struct packed {
		logic               rmw;      // read-modify-write of one pixel byte
		logic               rd;       // plain word read
		logic               word_wr;  // full word write
		logic [ADDR_W-1:0]  addr;
		logic               hi;       // high byte for odd x
		logic [COLOR_W-1:0] color;
	} req_t;

	// Sequencer to output register
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] read_data;
		logic              drawn;
	} res_t;

endpackage

`default_nettype wire

[sv/cfr_store.sv]
// Frame word memory with pixel read-modify-write pipeline and write-back forwarding.
`timescale 1ns / 1ps
`default_nettype none

module cfr_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cfr_pkg::req_t               req,
	output logic [cfr_pkg::WORD_W-1:0]       rd_data
);

	logic [cfr_pkg::WORD_W-1:0] mem [cfr_pkg::STORE_WORDS];

	logic [cfr_pkg::WORD_W-1:0]  rd_q;
	logic                        rmw_s1;
	logic [cfr_pkg::ADDR_W-1:0]  addr_s1;
	logic                        hi_s1;
	logic [cfr_pkg::COLOR_W-1:0] color_s1;

	logic                        fwd_valid_q;
	logic [cfr_pkg::ADDR_W-1:0]  fwd_addr_q;
	logic [cfr_pkg::WORD_W-1:0]  fwd_data_q;

	logic [cfr_pkg::WORD_W-1:0]  base;
	logic [cfr_pkg::WORD_W-1:0]  merged;
	logic                        wr_en;
	logic [cfr_pkg::ADDR_W-1:0]  wr_addr;
	logic [cfr_pkg::WORD_W-1:0]  wr_data;

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rmw || req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	// Stage 1 pixel request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_s1      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			rmw_s1      <= req.rmw;
			fwd_valid_q <= rmw_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= req.addr;
		hi_s1      <= req.hi;
		color_s1   <= req.color;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= merged;
	end

	// The read issued alongside last cycle's write saw the old word: take the written one
	always_comb begin
		base = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_q;
		if (hi_s1) begin
			merged = {color_s1, base[7:0]};
		end else begin
			merged = {base[15:8], color_s1};
		end
	end

	// Write port select: pixel write-back or full word fill
	always_comb begin
		wr_en   = rmw_s1 || req.word_wr;
		wr_addr = rmw_s1 ? addr_s1 : req.addr;
		wr_data = rmw_s1 ? merged : {req.color, req.color};
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[sv/cfr_scan.sv]
// Command sequencer: clipping, row/column scan, screen fill sweep and word read.
`timescale 1ns / 1ps
`default_nettype none

module cfr_scan (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_accept,
	input  wire cfr_pkg::cmd_t               cmd,
	input  wire logic [cfr_pkg::X_W-1:0]     w_eff,
	input  wire logic [cfr_pkg::Y_W-1:0]     h_eff,
	input  wire logic [cfr_pkg::WORD_W-1:0]  rd_data,
	input  wire logic                        res_ready,
	output logic                             idle,
	output cfr_pkg::req_t                    req,
	output cfr_pkg::res_t                    res
);

	cfr_pkg::scan_state_t state_q, state_d;
	cfr_pkg::cmd_t        cmd_q;

	logic [cfr_pkg::Y_W-1:0]    y_q, y_end_q;
	logic [cfr_pkg::X_W-1:0]    x_q, x_start_q, x_end_q;
	logic                       nonempty_q;
	logic [cfr_pkg::PIX_W-1:0]  row_base_q;
	logic [cfr_pkg::CNT_W-1:0]  cnt_q;
	logic [cfr_pkg::ADDR_W-1:0] fa_q;
	logic [cfr_pkg::WORD_W-1:0] res_data_q;
	logic                       res_drawn_q;

	// Clipping
	logic signed [cfr_pkg::CLIP_W-1:0] t_s, b_s, l_s, r_s, h_s, w_s;
	logic signed [cfr_pkg::CLIP_W-1:0] t_c, b_c, l_c, r_c;

	always_comb begin
		t_s = cfr_pkg::CLIP_W'(cmd_q.rect_top);
		b_s = cfr_pkg::CLIP_W'(cmd_q.rect_bottom);
		l_s = cfr_pkg::CLIP_W'(cmd_q.rect_left);
		r_s = cfr_pkg::CLIP_W'(cmd_q.rect_right);
		h_s = signed'(cfr_pkg::CLIP_W'(h_eff));
		w_s = signed'(cfr_pkg::CLIP_W'(w_eff));
		t_c = (t_s < 0) ? '0 : ((t_s > h_s) ? h_s : t_s);
		l_c = (l_s < 0) ? '0 : ((l_s > w_s) ? w_s : l_s);
		b_c = (b_s < cfr_pkg::CLIP_NEG_ONE) ? cfr_pkg::CLIP_NEG_ONE :
		      ((b_s > h_s - cfr_pkg::CLIP_W'(1)) ? h_s - cfr_pkg::CLIP_W'(1) : b_s);
		r_c = (r_s < cfr_pkg::CLIP_NEG_ONE) ? cfr_pkg::CLIP_NEG_ONE :
		      ((r_s > w_s - cfr_pkg::CLIP_W'(1)) ? w_s - cfr_pkg::CLIP_W'(1) : r_s);
	end

	// Shared multiplier: top row times width, or height times width
	logic [cfr_pkg::Y_W-1:0]    mul_a;
	logic [cfr_pkg::PROD_W-1:0] prod;
	logic [cfr_pkg::PIX_W-1:0]  prod_pix;
	logic [cfr_pkg::CNT_W-1:0]  fill_words;

	always_comb begin
		mul_a      = (cmd_q.op == cfr_pkg::OP_FILL_RECT) ? y_q : h_eff;
		prod       = cfr_pkg::PROD_W'(mul_a) * cfr_pkg::PROD_W'(w_eff);
		prod_pix   = cfr_pkg::PIX_W'(prod);
		fill_words = cfr_pkg::CNT_W'(prod_pix >> 1);
	end

	// Scan position
	logic [cfr_pkg::PIX_W-1:0] pix_idx;
	logic                      row_end, last_row, fill_last, raddr_ok;

	always_comb begin
		pix_idx   = row_base_q + cfr_pkg::PIX_W'(x_q);
		row_end   = (x_q == x_end_q);
		last_row  = (y_q == y_end_q);
		fill_last = ((cfr_pkg::CNT_W'(fa_q) + cfr_pkg::CNT_W'(1)) == cnt_q);
		raddr_ok  = (32'(cmd_q.read_address) < 32'(cfr_pkg::STORE_WORDS));
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory requests
	always_comb begin
		state_d     = state_q;
		idle        = 1'b0;
		req         = '0;
		req.color   = cmd_q.pixel_color;
		res.valid     = 1'b0;
		res.read_data = res_data_q;
		res.drawn     = res_drawn_q;
		unique case (state_q)
			cfr_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (cmd_accept) begin
					state_d = cfr_pkg::ST_SETUP;
				end
			end
			cfr_pkg::ST_SETUP: begin
				unique case (cmd_q.op)
					cfr_pkg::OP_FILL_RECT,
					cfr_pkg::OP_FILL_SCREEN: state_d = cfr_pkg::ST_MUL;
					cfr_pkg::OP_READ_WORD: begin
						req.rd   = raddr_ok;
						req.addr = cfr_pkg::ADDR_W'(cmd_q.read_address);
						state_d  = cfr_pkg::ST_RDWAIT;
					end
					default: state_d = cfr_pkg::ST_DONE;
				endcase
			end
			cfr_pkg::ST_MUL: begin
				if (cmd_q.op == cfr_pkg::OP_FILL_RECT) begin
					state_d = nonempty_q ? cfr_pkg::ST_SCAN : cfr_pkg::ST_DONE;
				end else begin
					state_d = (fill_words == '0) ? cfr_pkg::ST_DONE : cfr_pkg::ST_FILL;
				end
			end
			cfr_pkg::ST_SCAN: begin
				req.rmw  = 1'b1;
				req.addr = cfr_pkg::ADDR_W'(pix_idx >> 1);
				req.hi   = x_q[0];
				if (row_end && last_row) begin
					state_d = cfr_pkg::ST_DONE;
				end
			end
			cfr_pkg::ST_FILL: begin
				req.word_wr = 1'b1;
				req.addr    = fa_q;
				if (fill_last) begin
					state_d = cfr_pkg::ST_DONE;
				end
			end
			cfr_pkg::ST_RDWAIT: begin
				state_d = cfr_pkg::ST_DONE;
			end
			cfr_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = cfr_pkg::ST_IDLE;
				end
			end
			default: state_d = cfr_pkg::ST_IDLE;
		endcase
	end

	// Command and scan counters
	always_ff @(posedge clk) begin
		if (cmd_accept && (state_q == cfr_pkg::ST_IDLE)) begin
			cmd_q <= cmd;
		end
		unique case (state_q)
			cfr_pkg::ST_SETUP: begin
				y_q         <= cfr_pkg::Y_W'(t_c);
				y_end_q     <= cfr_pkg::Y_W'(b_c);
				x_q         <= cfr_pkg::X_W'(l_c);
				x_start_q   <= cfr_pkg::X_W'(l_c);
				x_end_q     <= cfr_pkg::X_W'(r_c);
				nonempty_q  <= (r_c >= l_c) && (b_c >= t_c);
				res_data_q  <= '0;
				res_drawn_q <= 1'b0;
			end
			cfr_pkg::ST_MUL: begin
				row_base_q <= prod_pix;
				cnt_q      <= fill_words;
				fa_q       <= '0;
			end
			cfr_pkg::ST_SCAN: begin
				if (row_end) begin
					x_q <= x_start_q;
					if (last_row) begin
						res_drawn_q <= 1'b1;
					end else begin
						y_q        <= y_q + cfr_pkg::Y_W'(1);
						row_base_q <= row_base_q + cfr_pkg::PIX_W'(w_eff);
					end
				end else begin
					x_q <= x_q + cfr_pkg::X_W'(1);
				end
			end
			cfr_pkg::ST_FILL: begin
				fa_q <= fa_q + cfr_pkg::ADDR_W'(1);
				if (fill_last) begin
					res_drawn_q <= 1'b1;
				end
			end
			cfr_pkg::ST_RDWAIT: begin
				res_data_q <= raddr_ok ? rd_data : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/clipped_rect_fill_framebuffer_core.sv]
// Top level: stream ports, configuration registers and result register around scan and store.
//
// Channel   Direction  Accepted when                  Carries
// s_axis    in         s_axis_tvalid & s_axis_tready  one command
// m_axis    out        m_axis_tvalid & m_axis_tready  one result per command
// cfg       in         cfg_valid & cfg_ready          register index and value
//
// Rectangle fill: setup and multiply states, then one covered pixel per cycle through a one-word
// read-modify-write pipeline on the single-port-read frame memory, then the done state to hand
// off. Screen fill: the same two states, then one word per cycle over (height*width)/2 words.
// A full result register holds the sequencer in its done state. Commands run one at a time;
// the result register lets the next command start while the previous result waits. Reset
// clears control state only; frame memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_framebuffer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// s_axis_tdata: operation[1:0], rect_top[13:2], rect_bottom[25:14], rect_left[37:26],
	//               rect_right[49:38], pixel_color[57:50], read_address[72:58], zeros
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [cfr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// m_axis_tdata: read_data[15:0], drawn[16], zeros
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [cfr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [cfr_pkg::CFG_WID_W-1:0] buffer_width_q;
	logic [cfr_pkg::CFG_HGT_W-1:0] buffer_height_q;
	logic [cfr_pkg::X_W-1:0]       w_eff;
	logic [cfr_pkg::Y_W-1:0]       h_eff;

	cfr_pkg::cmd_t  cmd;
	cfr_pkg::req_t  req;
	cfr_pkg::res_t  res;
	logic           scan_idle;
	logic           cmd_accept;
	logic           res_ready;
	logic [cfr_pkg::WORD_W-1:0] rd_data;

	logic                       out_valid_q;
	logic [cfr_pkg::WORD_W-1:0] out_data_q;
	logic                       out_drawn_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_width_q  <= cfr_pkg::CFG_WID_W'(256);
			buffer_height_q <= cfr_pkg::CFG_HGT_W'(192);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cfr_pkg::CFG_BUFFER_WIDTH:  buffer_width_q  <= cfg_data;
				cfr_pkg::CFG_BUFFER_HEIGHT: buffer_height_q <= cfg_data[cfr_pkg::CFG_HGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Width and height limited to the frame maximum
	always_comb begin
		w_eff = (32'(buffer_width_q) > 32'(cfr_pkg::MAX_WIDTH)) ?
		        cfr_pkg::X_W'(cfr_pkg::MAX_WIDTH) : cfr_pkg::X_W'(buffer_width_q);
		h_eff = (32'(buffer_height_q) > 32'(cfr_pkg::MAX_HEIGHT)) ?
		        cfr_pkg::Y_W'(cfr_pkg::MAX_HEIGHT) : cfr_pkg::Y_W'(buffer_height_q);
	end

	// Command unpack
	always_comb begin
		cmd.op           = cfr_pkg::op_t'(s_axis_tdata[1:0]);
		cmd.rect_top     = s_axis_tdata[13:2];
		cmd.rect_bottom  = s_axis_tdata[25:14];
		cmd.rect_left    = s_axis_tdata[37:26];
		cmd.rect_right   = s_axis_tdata[49:38];
		cmd.pixel_color  = s_axis_tdata[57:50];
		cmd.read_address = s_axis_tdata[72:58];
	end

	assign s_axis_tready = scan_idle;
	assign cmd_accept    = s_axis_tvalid && scan_idle;

	cfr_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_accept (cmd_accept),
		.cmd        (cmd),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.rd_data    (rd_data),
		.res_ready  (res_ready),
		.idle       (scan_idle),
		.req        (req),
		.res        (res)
	);

	cfr_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// Result register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_data_q  <= res.read_data;
			out_drawn_q <= res.drawn;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(cfr_pkg::OUT_TDATA_W - cfr_pkg::WORD_W - 1)'(0),
	                        out_drawn_q, out_data_q};

endmodule

`default_nettype wire
